@@ rtl/epaper_command_ram_controller_top_defines.svh @@
// Assertion macros for the display command controller.
`ifndef EPAPER_COMMAND_RAM_CONTROLLER_TOP_DEFINES_SVH
`define EPAPER_COMMAND_RAM_CONTROLLER_TOP_DEFINES_SVH

`ifndef SYNTH
`define ECRC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ECRC_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ECRC_ASSERT(lbl, clk, rst_n, prop, msg)
`define ECRC_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/ecrc_pkg.sv @@
`default_nettype none

package ecrc_pkg;

  localparam int RowBytesDefault  = 16;
  localparam int LineCountDefault = 250;
  localparam int AddrInW          = 12;
  localparam int CfgW             = 10;
  localparam int CfgIdxW          = 2;
  localparam int QueueDepth       = 2;

  localparam logic [2:0] ActCmd   = 3'd0;
  localparam logic [2:0] ActData  = 3'd1;
  localparam logic [2:0] ActFlush = 3'd2;
  localparam logic [2:0] ActTick  = 3'd3;
  localparam logic [2:0] ActRead  = 3'd4;

  localparam logic [7:0] CmdWriteBlack  = 8'h24;
  localparam logic [7:0] CmdWriteRed    = 8'h26;
  localparam logic [7:0] CmdWindowX     = 8'h44;
  localparam logic [7:0] CmdWindowY     = 8'h45;
  localparam logic [7:0] CmdColumn      = 8'h4E;
  localparam logic [7:0] CmdRow         = 8'h4F;
  localparam logic [7:0] CmdRefreshMode = 8'h22;
  localparam logic [7:0] CmdActivate    = 8'h20;
  localparam logic [7:0] CmdSoftReset   = 8'h12;
  localparam logic [7:0] ModeFull       = 8'hF7;
  localparam logic [7:0] RamFill        = 8'hFF;

  localparam logic [CfgIdxW-1:0] CfgResetBusy = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFullBusy  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgOtherBusy = 2'd2;

  localparam logic [CfgW-1:0] ResetBusyInit = 10'd50;
  localparam logic [CfgW-1:0] FullBusyInit  = 10'd100;
  localparam logic [CfgW-1:0] OtherBusyInit = 10'd50;

  typedef enum logic [2:0] {
    OpCmd,
    OpData,
    OpFlush,
    OpTick,
    OpRead,
    OpNone
  } ecrc_op_e;

  typedef struct packed {
    logic [2:0]         action;
    logic [7:0]         byte_value;
    logic [AddrInW-1:0] read_address;
    logic               read_plane;
  } ecrc_in_t;

  typedef struct packed {
    logic       busy_res;
    logic [7:0] read_data;
  } ecrc_out_t;

  typedef struct packed {
    ecrc_op_e           op;
    logic [7:0]         byte_value;
    logic [AddrInW-1:0] read_address;
    logic               read_plane;
  } ecrc_item_t;

endpackage

`default_nettype wire

@@ rtl/ecrc_front.sv @@
`default_nettype none

module ecrc_front import ecrc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire ecrc_in_t   in_data_i,
  output logic            in_stall_o,
  input  wire logic       hold_i,
  output logic            valid_o,
  output ecrc_item_t      item_o,
  input  wire logic       full_i
);

  logic       valid_q, valid_d;
  ecrc_item_t item_q, item_d;
  logic       accept;

  assign in_stall_o = hold_i || (valid_q && full_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_comb begin
    item_d              = item_q;
    item_d.byte_value   = in_data_i.byte_value;
    item_d.read_address = in_data_i.read_address;
    item_d.read_plane   = in_data_i.read_plane;
    unique case (in_data_i.action)
      ActCmd:   item_d.op = OpCmd;
      ActData:  item_d.op = OpData;
      ActFlush: item_d.op = OpFlush;
      ActTick:  item_d.op = OpTick;
      ActRead:  item_d.op = OpRead;
      default:  item_d.op = OpNone;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (valid_q && !full_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ecrc_queue.sv @@
`default_nettype none

module ecrc_queue import ecrc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire ecrc_item_t item_i,
  output logic            full_o,
  output logic            valid_o,
  output ecrc_item_t      item_o,
  input  wire logic       pop_i
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  ecrc_item_t            slots_q [QueueDepth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  do_push, do_pop;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_d = CntW'(count_q + 1'b1);
    end else if (do_pop && !do_push) begin
      count_d = CntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ecrc_back.sv @@
`default_nettype none

module ecrc_back import ecrc_pkg::*; #(
  parameter int RowBytes  = RowBytesDefault,
  parameter int LineCount = LineCountDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  input  wire ecrc_item_t         item_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  output ecrc_out_t               out_data_o,
  input  wire logic               out_stall_i,
  input  wire logic               cfg_valid_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  output logic                    clearing_o
);

  localparam int PlaneBytes = RowBytes * LineCount;
  localparam int AddrW      = (PlaneBytes > 1) ? $clog2(PlaneBytes) : 1;
  localparam int OffW       = 16 + $clog2(RowBytes) + 2;

  localparam logic [1:0] StRun   = 2'd0;
  localparam logic [1:0] StRead  = 2'd1;
  localparam logic [1:0] StClear = 2'd2;

  logic [7:0] blk_mem [PlaneBytes];
  logic [7:0] red_mem [PlaneBytes];

  logic [1:0]       state_q, state_d;
  logic [AddrW-1:0] clr_cnt_q, clr_cnt_d;
  logic [7:0]       wx_first_q, wx_first_d, wx_last_q, wx_last_d;
  logic [15:0]      wy_first_q, wy_first_d, wy_last_q, wy_last_d;
  logic [8:0]       col_q, col_d;
  logic [15:0]      row_q, row_d;
  logic [7:0]       pend_q, pend_d;
  logic [7:0]       args_q [4];
  logic [7:0]       args_d [4];
  logic [8:0]       argc_q, argc_d;
  logic [7:0]       mode_q, mode_d;
  logic             busy_q, busy_d;
  logic [CfgW-1:0]  ms_left_q, ms_left_d;
  logic [CfgW-1:0]  reset_ms_q, full_ms_q, other_ms_q;
  logic             out_valid_q, out_valid_d;
  ecrc_out_t        out_data_q, out_data_d;
  logic [7:0]       blk_rd_q, red_rd_q;
  logic             rd_plane_q, rd_ok_q;

  logic             out_free, pop, run;
  logic             blk_we, red_we, rd_en;
  logic [AddrW-1:0] wr_idx, rd_idx;
  logic [7:0]       wr_data;
  logic [OffW-1:0]  off;
  logic             off_ok;
  logic [8:0]       col_inc;
  logic [15:0]      row_inc;
  logic [CfgW-1:0]  act_ms;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign pop         = (state_q == StRun) && q_valid_i && out_free;
  assign run         = pop && (item_i.op == OpCmd || item_i.op == OpFlush);
  assign pop_o       = pop;
  assign clearing_o  = (state_q == StClear);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign off     = OffW'(row_q) * OffW'(RowBytes) + OffW'(col_q);
  assign off_ok  = off < OffW'(PlaneBytes);
  assign col_inc = col_q + 9'd1;
  assign row_inc = row_q + 16'd1;
  assign act_ms  = (mode_q == ModeFull) ? full_ms_q : other_ms_q;
  assign rd_en   = pop && (item_i.op == OpRead);
  assign rd_idx  = AddrW'(item_i.read_address);

  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    wx_first_d = wx_first_q;
    wx_last_d  = wx_last_q;
    wy_first_d = wy_first_q;
    wy_last_d  = wy_last_q;
    col_d      = col_q;
    row_d      = row_q;
    pend_d     = pend_q;
    args_d     = args_q;
    argc_d     = argc_q;
    mode_d     = mode_q;
    busy_d     = busy_q;
    ms_left_d  = ms_left_q;
    blk_we     = 1'b0;
    red_we     = 1'b0;
    wr_idx     = off[AddrW-1:0];
    wr_data    = item_i.byte_value;

    if (state_q == StClear) begin
      blk_we    = 1'b1;
      red_we    = 1'b1;
      wr_idx    = clr_cnt_q;
      wr_data   = RamFill;
      clr_cnt_d = AddrW'(clr_cnt_q + 1'b1);
      if (clr_cnt_q == AddrW'(PlaneBytes - 1)) begin
        state_d = StRun;
      end
    end else if (state_q == StRead && out_free) begin
      state_d = StRun;
    end

    if (run) begin
      unique case (pend_q)
        CmdSoftReset: begin
          wx_first_d = 8'd0;
          wx_last_d  = 8'd15;
          wy_first_d = 16'd0;
          wy_last_d  = 16'd249;
          col_d      = 9'd0;
          row_d      = 16'd0;
          pend_d     = 8'd0;
          args_d     = '{default: 8'd0};
          argc_d     = 9'd0;
          mode_d     = 8'd0;
          busy_d     = 1'b1;
          if (reset_ms_q != '0) begin
            ms_left_d = reset_ms_q;
          end
          state_d    = StClear;
          clr_cnt_d  = '0;
        end
        CmdActivate: begin
          busy_d = 1'b1;
          if (act_ms != '0) begin
            ms_left_d = act_ms;
          end
        end
        CmdRefreshMode: begin
          if (argc_q >= 9'd1) begin
            mode_d = args_q[0];
          end
          argc_d = 9'd0;
        end
        CmdWindowX: begin
          if (argc_q >= 9'd2) begin
            wx_first_d = args_q[0];
            wx_last_d  = args_q[1];
          end
          argc_d = 9'd0;
        end
        CmdWindowY: begin
          if (argc_q >= 9'd4) begin
            wy_first_d = {args_q[1], args_q[0]};
            wy_last_d  = {args_q[3], args_q[2]};
          end
          argc_d = 9'd0;
        end
        CmdColumn: begin
          if (argc_q >= 9'd1) begin
            col_d = {1'b0, args_q[0]};
          end
          argc_d = 9'd0;
        end
        CmdRow: begin
          if (argc_q >= 9'd2) begin
            row_d = {args_q[1], args_q[0]};
          end
          argc_d = 9'd0;
        end
        default: begin
          argc_d = 9'd0;
        end
      endcase
    end

    if (pop) begin
      unique case (item_i.op)
        OpCmd: begin
          pend_d = item_i.byte_value;
          argc_d = 9'd0;
        end
        OpData: begin
          if (pend_q == CmdWriteBlack || pend_q == CmdWriteRed) begin
            blk_we = off_ok && (pend_q == CmdWriteBlack);
            red_we = off_ok && (pend_q == CmdWriteRed);
            if (col_inc > {1'b0, wx_last_q}) begin
              col_d = {1'b0, wx_first_q};
              row_d = (row_inc > wy_last_q) ? wy_first_q : row_inc;
            end else begin
              col_d = col_inc;
            end
          end else begin
            if (argc_q < 9'd4) begin
              args_d[argc_q[1:0]] = item_i.byte_value;
            end
            if (argc_q < 9'd256) begin
              argc_d = argc_q + 9'd1;
            end
          end
        end
        OpTick: begin
          if (ms_left_q != '0) begin
            ms_left_d = CfgW'(ms_left_q - 1'b1);
            if (ms_left_q == CfgW'(1)) begin
              busy_d = 1'b0;
            end
          end
        end
        OpFlush, OpRead, OpNone: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (pop && item_i.op != OpRead) begin
      out_valid_d          = 1'b1;
      out_data_d.busy_res  = busy_d;
      out_data_d.read_data = 8'd0;
    end else if (state_q == StRead && out_free) begin
      out_valid_d          = 1'b1;
      out_data_d.busy_res  = busy_q;
      out_data_d.read_data = !rd_ok_q ? 8'd0 : (rd_plane_q ? red_rd_q : blk_rd_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_cnt_q   <= '0;
      wx_first_q  <= 8'd0;
      wx_last_q   <= 8'd15;
      wy_first_q  <= 16'd0;
      wy_last_q   <= 16'd249;
      col_q       <= 9'd0;
      row_q       <= 16'd0;
      pend_q      <= 8'd0;
      args_q      <= '{default: 8'd0};
      argc_q      <= 9'd0;
      mode_q      <= 8'd0;
      busy_q      <= 1'b0;
      ms_left_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= (rd_en) ? StRead : state_d;
      clr_cnt_q   <= clr_cnt_d;
      wx_first_q  <= wx_first_d;
      wx_last_q   <= wx_last_d;
      wy_first_q  <= wy_first_d;
      wy_last_q   <= wy_last_d;
      col_q       <= col_d;
      row_q       <= row_d;
      pend_q      <= pend_d;
      args_q      <= args_d;
      argc_q      <= argc_d;
      mode_q      <= mode_d;
      busy_q      <= busy_d;
      ms_left_q   <= ms_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_ms_q <= ResetBusyInit;
      full_ms_q  <= FullBusyInit;
      other_ms_q <= OtherBusyInit;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgResetBusy: reset_ms_q <= cfg_data_i;
        CfgFullBusy:  full_ms_q  <= cfg_data_i;
        CfgOtherBusy: other_ms_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (rd_en) begin
      rd_plane_q <= item_i.read_plane;
      rd_ok_q    <= (32'(item_i.read_address) < 32'(PlaneBytes));
    end
  end

  always_ff @(posedge clk_i) begin
    if (blk_we) begin
      blk_mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      blk_rd_q <= blk_mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (red_we) begin
      red_mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      red_rd_q <= red_mem[rd_idx];
    end
  end

endmodule

`default_nettype wire

@@ rtl/epaper_command_ram_controller_top.sv @@
// Command interface and two-plane display RAM for a small e-paper panel.
// The input channel carries one action per transfer: command byte, data byte,
// select release, millisecond tick or RAM read. Every input transfer yields
// exactly one output transfer with the busy level and, for reads, the RAM byte.
// Three busy-time registers are written over the config channel, which is
// always ready; write them only while the block is idle.
// An accepted item passes a classify register, a two-entry queue and the
// execute stage into the output register; a read also passes the read port.
// The execute stage retires one item per cycle while the output is free;
// after a read it takes no new item until the registered read result is out.
// After reset, and after a software reset command, both planes are swept to
// 0xFF one byte per cycle over ROW_BYTES_PER_LINE * LINE_COUNT bytes (4000 by
// default), and the input channel stalls while the sweep runs.
// When the receiver stalls, the result holds in the output register, the
// queue fills, and then in_stall_o rises; nothing is dropped.
`default_nettype none

`include "epaper_command_ram_controller_top_defines.svh"

module epaper_command_ram_controller_top import ecrc_pkg::*; #(
  parameter int ROW_BYTES_PER_LINE = RowBytesDefault,
  parameter int LINE_COUNT         = LineCountDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire ecrc_in_t           in_data_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  output ecrc_out_t               out_data_o,
  input  wire logic               out_stall_i,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i
);

  logic       fr_valid, q_full, q_valid, q_pop, clearing;
  ecrc_item_t fr_item, q_item;

  assign cfg_ready_o = 1'b1;

  ecrc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .hold_i     (clearing),
    .valid_o    (fr_valid),
    .item_o     (fr_item),
    .full_i     (q_full)
  );

  ecrc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .item_i  (fr_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (q_pop)
  );

  ecrc_back #(
    .RowBytes  (ROW_BYTES_PER_LINE),
    .LineCount (LINE_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .item_i      (q_item),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .clearing_o  (clearing)
  );

  `ECRC_ASSERT(a_pop_needs_item, clk_i, rst_ni, q_pop |-> q_valid, "pop from empty queue")
  `ECRC_ASSERT(a_clear_blocks_input, clk_i, rst_ni, clearing |-> in_stall_o, "input open while clearing")
  `ECRC_ASSERT(a_no_result_from_clear, clk_i, rst_ni, $rose(out_valid_o) |-> !$past(clearing), "result during clear")
  `ECRC_ASSERT_NORST(a_reset_no_result, clk_i, !rst_ni |=> !out_valid_o, "result during reset")

endmodule

`default_nettype wire
